[design/rde_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rde_pkg: shared definitions for the radix digit emitter
// Sizes, ASCII constants, the divider result bundle and small helper
// functions used by the top level and the divider.
// ----------------------------------------------------------------------------
package rde_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int DIGIT_DEPTH = 32;

    localparam int DIGIT_W = 4;
    localparam int CHAR_W  = 7;
    localparam int RADIX_W = 5;
    localparam int IDX_W   = $clog2(DIGIT_DEPTH);
    localparam int CNT_W   = $clog2(DIGIT_DEPTH + 1);
    localparam int STEP_W  = $clog2(VALUE_WIDTH + 1);

    localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
    localparam logic [RADIX_W-1:0] BASE_MIN    = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] BASE_MAX    = RADIX_W'(16);

    localparam logic [CHAR_W-1:0]  ASCII_ZERO    = CHAR_W'(48);
    localparam logic [CHAR_W-1:0]  LETTER_OFFSET = CHAR_W'(55);
    localparam logic [DIGIT_W-1:0] FIRST_LETTER  = DIGIT_W'(10);

    // Result bundle handed from the divider to the sequencer.
    typedef struct packed {
        logic                   done;
        logic [VALUE_WIDTH-1:0] quot;
        logic [DIGIT_W-1:0]     rem;
    } div_res_t;

    // Out-of-range radix values saturate to the nearest legal base.
    function automatic logic [RADIX_W-1:0] eff_base(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] b;
        b = r;
        if (b < BASE_MIN)
        begin
            b = BASE_MIN;
        end
        if (b > BASE_MAX)
        begin
            b = BASE_MAX;
        end
        return b;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < FIRST_LETTER)
        begin
            c = CHAR_W'(d) + ASCII_ZERO;
        end
        else
        begin
            c = CHAR_W'(d) + LETTER_OFFSET;
        end
        return c;
    endfunction

endpackage

[design/rde_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rde_ram: generic single-write, single-read memory
// One write port and one read port with a registered read output.
// ----------------------------------------------------------------------------
module rde_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/rde_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rde_div: bit-serial restoring divider
// Divides an unsigned value by a small base, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rde_div
    import rde_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [VALUE_WIDTH-1:0] dividend,
    input  logic [RADIX_W-1:0]     divisor,
    output div_res_t               res
);

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic [VALUE_WIDTH-1:0] q_reg, q_next;
    logic [DIGIT_W-1:0]     rem_reg, rem_next;
    logic [RADIX_W-1:0]     base_reg, base_next;
    logic [RADIX_W-1:0]     trial;
    logic                   fits;

    // The remainder stays below the base, so the shifted trial fits in five bits.
    assign trial = {rem_reg, q_reg[VALUE_WIDTH-1]};
    assign fits  = (trial >= base_reg);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        base_next = base_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(VALUE_WIDTH);
            q_next    = dividend;
            rem_next  = '0;
            base_next = divisor;
        end
        else if (busy_reg)
        begin
            q_next    = {q_reg[VALUE_WIDTH-2:0], fits};
            rem_next  = fits ? DIGIT_W'(trial - base_reg) : trial[DIGIT_W-1:0];
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg    <= q_next;
        rem_reg  <= rem_next;
        base_reg <= base_next;
    end

    assign res.done = done_reg;
    assign res.quot = q_reg;
    assign res.rem  = rem_reg;

endmodule

[design/radix_digit_emitter_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_digit_emitter_top: integer to ASCII digits in base 2 to 16
// Converts a signed integer into its digits in the configured base and
// streams them out as ASCII characters, most significant digit first.
// ----------------------------------------------------------------------------
// Each digit comes from the shared bit-serial divider, which loads its operands
// and then works through each bit of the 32-bit value; each emitted digit
// passes through the digit store read and the output load.
// At most 31 digits are emitted for one item.
// Zero and negative inputs give one result item, by way of ST_SPECIAL.
// rst_n clears the sequencer, the output valid and sets radix to 10.
module radix_digit_emitter_top
    import rde_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    // Configuration: radix register, written whenever radix_we is high.
    input  logic               radix_we,
    input  logic [RADIX_W-1:0] radix_wdata,

    // Input stream. tdata: [31:0] value (two's complement).
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [31:0]        s_tdata,

    // Output stream. tdata: [6:0] digit_char, [7] zero fill.
    // tlast: last_digit. tuser: [0] negative_error.
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [7:0]         m_tdata,
    output logic               m_tlast,
    output logic               m_tuser
);

    // The sequencer walks through division, then reads digits back out.
    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_SPECIAL = 5'b00010,
        ST_DIV     = 5'b00100,
        ST_READ    = 5'b01000,
        ST_LOAD    = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    logic [RADIX_W-1:0] radix_reg;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               neg_reg, neg_next;

    // Output register. It holds one finished item until the sink takes it.
    logic               out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]  char_reg, char_next;
    logic               last_reg, last_next;
    logic               err_reg, err_next;
    logic               out_free;

    logic                   accept;
    logic                   in_neg;
    logic                   in_zero;
    logic                   div_start;
    logic [VALUE_WIDTH-1:0] div_dividend;
    div_res_t               div_res;

    logic                   ram_we;
    logic                   ram_re;
    logic [IDX_W-1:0]       ram_raddr;
    logic [DIGIT_W-1:0]     ram_rdata;
    logic [CNT_W-1:0]       count_inc;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign in_neg   = s_tdata[VALUE_WIDTH-1];
    assign in_zero  = (s_tdata == '0);
    assign out_free = !out_valid_reg || m_tready;

    assign count_inc = count_reg + CNT_W'(1);

    // The divider is started on a fresh positive value, and again on its own
    // quotient for as long as digits remain and the store has room.
    assign div_dividend = (state_reg == ST_IDLE) ? s_tdata : div_res.quot;

    assign ram_we    = (state_reg == ST_DIV) && div_res.done;
    assign ram_re    = (state_reg == ST_READ);
    assign ram_raddr = IDX_W'(count_reg - CNT_W'(1));

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        neg_next       = neg_reg;
        div_start      = 1'b0;
        out_valid_next = out_valid_reg && !m_tready;
        char_next      = char_reg;
        last_next      = last_reg;
        err_next       = err_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_neg || in_zero)
                    begin
                        neg_next   = in_neg;
                        state_next = ST_SPECIAL;
                    end
                    else
                    begin
                        count_next = '0;
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_SPECIAL:
            begin
                // A negative value gives a single error item, zero a single '0'.
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = neg_reg ? '0 : ASCII_ZERO;
                    last_next      = 1'b1;
                    err_next       = neg_reg;
                    state_next     = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                if (div_res.done)
                begin
                    count_next = count_inc;
                    if ((div_res.quot == '0) || (count_inc == CNT_W'(DIGIT_DEPTH)))
                    begin
                        state_next = ST_READ;
                    end
                    else
                    begin
                        div_start = 1'b1;
                    end
                end
            end
            ST_READ:
            begin
                // The store is popped from the most significant digit down.
                count_next = count_reg - CNT_W'(1);
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = digit_to_ascii(ram_rdata);
                    last_next      = (count_reg == '0);
                    err_next       = 1'b0;
                    state_next     = (count_reg == '0) ? ST_IDLE : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            radix_reg     <= RADIX_RESET;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (radix_we)
            begin
                radix_reg <= radix_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg  <= neg_next;
        char_reg <= char_next;
        last_reg <= last_next;
        err_reg  <= err_next;
    end

    rde_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (eff_base(radix_reg)),
        .res      (div_res)
    );

    // Digit store: remainders are written least significant first.
    rde_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (DIGIT_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (div_res.rem),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, char_reg};
    assign m_tlast  = last_reg;
    assign m_tuser  = err_reg;

endmodule

[design/rde_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rde_checker: port-level checks for the radix digit emitter
// Watches the top-level ports and flags behavior the block must never show.
// ----------------------------------------------------------------------------
module rde_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [7:0]         m_tdata,
    input logic               m_tlast,
    input logic               m_tuser
);

    // A stalled output item keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
            && $stable(m_tlast) && $stable(m_tuser))
        else $error("output item changed while stalled");

    // The block works on one item at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a conversion is running");

    // The error item is a lone, last item with a zero character.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast && (m_tdata == 8'h00))
        else $error("malformed error item");

    // Digit items carry only '0'-'9' or 'A'-'F'.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> ((m_tdata >= 8'h30) && (m_tdata <= 8'h39))
            || ((m_tdata >= 8'h41) && (m_tdata <= 8'h46)))
        else $error("digit item outside the digit alphabet");

endmodule

bind radix_digit_emitter_top rde_checker u_rde_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .m_tuser     (m_tuser)
);
